/* rtl/atr_pkg.sv */
`default_nettype none
package atr_pkg;

    // Field widths fixed by the request and result formats
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 4;
    localparam int ADDR_W   = 64;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    // Request function codes
    localparam func_t FN_START  = 3'd0;
    localparam func_t FN_STOP   = 3'd1;
    localparam func_t FN_ALLOC  = 3'd2;
    localparam func_t FN_FREE   = 3'd3;
    localparam func_t FN_FINISH = 3'd4;

    // Result status codes
    localparam status_t ST_OK           = 4'd0;
    localparam status_t ST_NOT_REC      = 4'd1;
    localparam status_t ST_HEAP_FULL    = 4'd2;
    localparam status_t ST_LIVE_REALLOC = 4'd3;
    localparam status_t ST_DOUBLE_FREE  = 4'd4;
    localparam status_t ST_UNALLOC_FREE = 4'd5;
    localparam status_t ST_TABLE_FULL   = 4'd6;
    localparam status_t ST_LEAK         = 4'd7;
    localparam status_t ST_DONE         = 4'd8;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture accepted request
        logic compare;     // register parallel address match
        logic commit;      // update table, load result for non-finish request
        logic sweep_init;  // begin leak sweep
        logic scan_step;   // examine one table entry
        logic emit_leak;   // load leak result, rescan above it
        logic emit_done;   // load done result
    } atr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_finish;   // captured request is a finish sweep
        logic slot_free;   // result register can take a new item
        logic scan_last;   // scanner sits on the last entry
        logic best_found;  // sweep pass found a live entry
    } atr_stat_t;

endpackage
`default_nettype wire

/* rtl/atr_event_if.sv */
`default_nettype none
interface atr_event_if;
    import atr_pkg::*;

    logic  valid;
    logic  ready;
    func_t func;
    addr_t addr;

    modport source (output valid, output func, output addr, input ready);
    modport sink   (input valid, input func, input addr, output ready);
endinterface
`default_nettype wire

/* rtl/atr_result_if.sv */
`default_nettype none
interface atr_result_if;
    import atr_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    addr_t   report_addr;
    logic    last;

    modport source (output valid, output status, output report_addr, output last,
                    input ready);
    modport sink   (input valid, input status, input report_addr, input last,
                    output ready);
endinterface
`default_nettype wire

/* rtl/atr_ctrl.sv */
`default_nettype none
module atr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  atr_pkg::atr_stat_t    stat,
    output atr_pkg::atr_cmd_t     cmd
);
    import atr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_ACT  = 5'b00100,
        S_SCAN = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_ACT;
            end
            S_ACT:
            begin
                if (stat.is_finish)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (stat.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.slot_free)
                begin
                    if (stat.best_found)
                    begin
                        cmd.emit_leak = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        cmd.emit_done = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is only loaded when the output register can take it
    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.emit_leak || cmd.emit_done) |-> stat.slot_free)
        else $error("result loaded while output register busy");

    // A leak is only reported when the pass found a live entry
    a_leak_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_leak |-> stat.best_found)
        else $error("leak emitted without a candidate");

    // The scanner only leaves a pass through the emit step
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> (state_reg == S_SCAN || state_reg == S_EMIT))
        else $error("sweep scan left unexpectedly");

endmodule
`default_nettype wire

/* rtl/atr_datapath.sv */
`default_nettype none
module atr_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  atr_pkg::func_t        in_func,
    input  atr_pkg::addr_t        in_addr,
    input  atr_pkg::atr_cmd_t     cmd,
    output atr_pkg::atr_stat_t    stat,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output atr_pkg::status_t      out_status,
    output atr_pkg::addr_t        out_addr,
    output logic                  out_last
);
    import atr_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Lowest set bit of a slot vector
    function automatic logic [IDX_W-1:0] lowest(input logic [TABLE_DEPTH-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Captured request
    func_t func_reg, func_next;
    addr_t addr_reg, addr_next;

    // Table state
    logic                   recording_reg, recording_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] freed_reg, freed_next;
    addr_t                  tab_reg [TABLE_DEPTH];
    addr_t                  tab_next [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_reg, hit_next;

    // Sweep scanner
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    addr_t            best_reg, best_next;
    logic             found_reg, found_next;
    addr_t            prev_reg, prev_next;
    logic             have_prev_reg, have_prev_next;

    // Result register
    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    addr_t   out_addr_reg, out_addr_next;
    logic    out_last_reg, out_last_next;

    logic             slot_free;
    logic             hit_any;
    logic [IDX_W-1:0] hit_idx;
    logic             empty_any;
    logic [IDX_W-1:0] empty_idx;
    addr_t            scan_addr;
    logic             scan_live;
    logic             candidate;
    logic             res_load;
    status_t          res_status;
    addr_t            res_addr;
    logic             res_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign hit_any   = |hit_reg;
    assign hit_idx   = lowest(hit_reg);
    assign empty_any = ~&valid_reg;
    assign empty_idx = lowest(~valid_reg);

    // Entry under the sweep scanner
    assign scan_addr = tab_reg[scan_idx_reg];
    assign scan_live = valid_reg[scan_idx_reg] && !freed_reg[scan_idx_reg];
    assign candidate = scan_live && (!have_prev_reg || (scan_addr > prev_reg))
                       && (!found_reg || (scan_addr < best_reg));

    assign stat.is_finish  = (func_reg == FN_FINISH);
    assign stat.slot_free  = slot_free;
    assign stat.scan_last  = (scan_idx_reg == LAST_IDX);
    assign stat.best_found = found_reg;

    // Request capture, lookup, table update and sweep
    always_comb
    begin
        func_next      = func_reg;
        addr_next      = addr_reg;
        recording_next = recording_reg;
        valid_next     = valid_reg;
        freed_next     = freed_reg;
        tab_next       = tab_reg;
        hit_next       = hit_reg;
        scan_idx_next  = scan_idx_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        res_load       = 1'b0;
        res_status     = ST_OK;
        res_addr       = '0;
        res_last       = 1'b1;

        if (cmd.load)
        begin
            func_next = in_func;
            addr_next = in_addr;
        end

        // Parallel address compare against every valid entry
        if (cmd.compare)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                hit_next[i] = valid_reg[i] && (tab_reg[i] == addr_reg);
            end
        end

        if (cmd.commit)
        begin
            res_load = 1'b1;
            unique case (func_reg)
                FN_START:
                begin
                    recording_next = 1'b1;
                end
                FN_STOP:
                begin
                    recording_next = 1'b0;
                end
                FN_ALLOC:
                begin
                    res_addr = addr_reg;
                    if (!recording_reg)
                    begin
                        res_status = ST_NOT_REC;
                    end
                    else if (addr_reg == '0)
                    begin
                        res_status = ST_HEAP_FULL;
                        res_addr   = '0;
                    end
                    else if (hit_any)
                    begin
                        if (freed_reg[hit_idx])
                        begin
                            freed_next[hit_idx] = 1'b0;
                        end
                        else
                        begin
                            res_status = ST_LIVE_REALLOC;
                        end
                    end
                    else if (empty_any)
                    begin
                        valid_next[empty_idx] = 1'b1;
                        freed_next[empty_idx] = 1'b0;
                        tab_next[empty_idx]   = addr_reg;
                    end
                    else
                    begin
                        res_status = ST_TABLE_FULL;
                    end
                end
                FN_FREE:
                begin
                    res_addr = addr_reg;
                    if (!recording_reg)
                    begin
                        res_status = ST_NOT_REC;
                    end
                    else if (!hit_any)
                    begin
                        res_status = ST_UNALLOC_FREE;
                    end
                    else if (freed_reg[hit_idx])
                    begin
                        res_status = ST_DOUBLE_FREE;
                    end
                    else
                    begin
                        freed_next[hit_idx] = 1'b1;
                    end
                end
                default:
                begin
                    // unused codes: plain ok, address zero
                end
            endcase
        end

        // Sweep: one entry per cycle, smallest live address above the last report
        if (cmd.sweep_init)
        begin
            scan_idx_next  = '0;
            found_next     = 1'b0;
            have_prev_next = 1'b0;
        end

        if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
            if (candidate)
            begin
                best_next  = scan_addr;
                found_next = 1'b1;
            end
        end

        if (cmd.emit_leak)
        begin
            res_load       = 1'b1;
            res_status     = ST_LEAK;
            res_addr       = best_reg;
            res_last       = 1'b0;
            prev_next      = best_reg;
            have_prev_next = 1'b1;
            scan_idx_next  = '0;
            found_next     = 1'b0;
        end

        if (cmd.emit_done)
        begin
            res_load   = 1'b1;
            res_status = ST_DONE;
            res_addr   = '0;
            res_last   = 1'b1;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_last_next   = out_last_reg;
        if (res_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_addr_next   = res_addr;
            out_last_next   = res_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recording_reg <= 1'b0;
            valid_reg     <= '0;
            hit_reg       <= '0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            recording_reg <= recording_next;
            valid_reg     <= valid_next;
            hit_reg       <= hit_next;
            found_reg     <= found_next;
            have_prev_reg <= have_prev_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        addr_reg       <= addr_next;
        freed_reg      <= freed_next;
        tab_reg        <= tab_next;
        best_reg       <= best_next;
        prev_reg       <= prev_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_addr   = out_addr_reg;
    assign out_last   = out_last_reg;

    // Valid entries hold distinct addresses, so at most one lookup hit
    a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_reg))
        else $error("address found in more than one slot");

    // Only leak items leave last low
    a_last_leak: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_status_reg == ST_LEAK))
        else $error("non-final result that is not a leak");

    // Address zero is never stored, so never reported as a leak
    a_leak_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_LEAK)) |-> (out_addr_reg != '0))
        else $error("leak reported at address zero");

endmodule
`default_nettype wire

/* rtl/allocation_tracker_table.sv */
`default_nettype none
// Heap allocation tracker. Each request (start, stop, allocation, free, finish)
// is checked against a table of TABLE_DEPTH address slots held in flip-flops,
// with one registered parallel compare per lookup. Start, stop, allocation and
// free each give one result item, loaded after the capture and compare steps
// once the result register is free; the next request is taken in the cycle
// after that, so requests are handled one at a time. A finish sweep reports
// live entries in ascending address order with a scanner that visits one slot
// per cycle, making one full pass per leak and a final pass. The result
// register lets a request be taken while the previous result still waits.
// The table is empty and recording is off after reset.
module allocation_tracker_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    atr_event_if.sink       event_ch,
    atr_result_if.source    result_ch
);
    import atr_pkg::*;

    atr_cmd_t  cmd;
    atr_stat_t stat;

    atr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (event_ch.valid),
        .in_ready (event_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    atr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_func    (event_ch.func),
        .in_addr    (event_ch.addr),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (result_ch.valid),
        .out_ready  (result_ch.ready),
        .out_status (result_ch.status),
        .out_addr   (result_ch.report_addr),
        .out_last   (result_ch.last)
    );

endmodule
`default_nettype wire

/* tb/testbench.sv */
module testbench;
    import atr_pkg::*;

    localparam int    DEPTH       = 32;
    localparam int    RANDOM_REQS = 300;
    localparam int    POOL_SIZE   = 40;
    localparam int    DRAIN_WAIT  = 64;
    localparam int    CYCLE_LIMIT = 2000000;

    // Function codes the block answers with a plain ok
    localparam func_t FN_SPARE_LO  = 3'd5;
    localparam func_t FN_SPARE_MID = 3'd6;
    localparam func_t FN_SPARE_HI  = 3'd7;

    localparam addr_t ADDR_ZERO = '0;
    localparam addr_t ADDR_MAX  = {ADDR_W{1'b1}};
    localparam addr_t ADDR_MSB  = 64'h8000_0000_0000_0000;
    localparam addr_t ADDR_ODD  = 64'h5555_5555_5555_5555;
    localparam addr_t ADDR_EVEN = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef struct packed {
        status_t status;
        addr_t   addr;
        logic    last;
    } report_t;

    // One directed request; typed rows carry their single expected report
    typedef struct packed {
        func_t   func;
        addr_t   addr;
        logic    typed;
        status_t status;
        addr_t   rep_addr;
    } step_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        // not recording after reset
        '{FN_ALLOC,     64'h1234,  1'b1, ST_NOT_REC,      64'h1234},
        '{FN_FREE,      ADDR_MAX,  1'b1, ST_NOT_REC,      ADDR_MAX},
        '{FN_FINISH,    ADDR_ODD,  1'b1, ST_DONE,         ADDR_ZERO},
        '{FN_START,     ADDR_EVEN, 1'b1, ST_OK,           ADDR_ZERO},
        // allocation cases
        '{FN_ALLOC,     ADDR_ZERO, 1'b1, ST_HEAP_FULL,    ADDR_ZERO},
        '{FN_ALLOC,     ADDR_MAX,  1'b1, ST_OK,           ADDR_MAX},
        '{FN_ALLOC,     64'd1,     1'b1, ST_OK,           64'd1},
        '{FN_ALLOC,     ADDR_MSB,  1'b1, ST_OK,           ADDR_MSB},
        '{FN_ALLOC,     ADDR_MAX,  1'b1, ST_LIVE_REALLOC, ADDR_MAX},
        // free cases
        '{FN_FREE,      64'd1,     1'b1, ST_OK,           64'd1},
        '{FN_FREE,      64'd1,     1'b1, ST_DOUBLE_FREE,  64'd1},
        '{FN_FREE,      ADDR_ZERO, 1'b1, ST_UNALLOC_FREE, ADDR_ZERO},
        '{FN_FREE,      ADDR_ODD,  1'b1, ST_UNALLOC_FREE, ADDR_ODD},
        // revive a freed entry
        '{FN_ALLOC,     64'd1,     1'b1, ST_OK,           64'd1},
        // leak sweeps, repeated
        '{FN_FINISH,    ADDR_ZERO, 1'b0, ST_OK,           ADDR_ZERO},
        '{FN_FREE,      ADDR_MSB,  1'b1, ST_OK,           ADDR_MSB},
        '{FN_FINISH,    ADDR_MAX,  1'b0, ST_OK,           ADDR_ZERO},
        // unused codes
        '{FN_SPARE_LO,  ADDR_EVEN, 1'b1, ST_OK,           ADDR_ZERO},
        '{FN_SPARE_HI,  ADDR_MAX,  1'b1, ST_OK,           ADDR_ZERO},
        // sweep while stopped
        '{FN_STOP,      ADDR_ODD,  1'b1, ST_OK,           ADDR_ZERO},
        '{FN_FINISH,    ADDR_ZERO, 1'b0, ST_OK,           ADDR_ZERO},
        '{FN_START,     ADDR_ZERO, 1'b1, ST_OK,           ADDR_ZERO},
        '{FN_SPARE_MID, ADDR_ODD,  1'b1, ST_OK,           ADDR_ZERO}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        quiet_phase = 1'b0;
    int unsigned cycle_count = 0;
    int          fail_count = 0;

    // Shadow of the allocation table
    logic        tracking_on;
    logic        slot_used  [DEPTH];
    addr_t       slot_addr  [DEPTH];
    logic        slot_freed [DEPTH];

    report_t     expected_q [$];
    addr_t       addr_pool  [POOL_SIZE];

    atr_event_if  event_ch ();
    atr_result_if result_ch ();

    allocation_tracker_table #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_ch  (event_ch),
        .result_ch (result_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL allocation_tracker_table");
            $finish;
        end
    end

    function automatic addr_t rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic int draw_wait();
        return quiet_phase ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void clear_table();
        tracking_on = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_addr[i]  = '0;
            slot_freed[i] = 1'b0;
        end
    endfunction

    // Apply one request to the shadow table and queue the reports it causes
    function automatic void track_request(input func_t f, input addr_t a);
        int    hit;
        int    empty;
        int    best;
        logic  have_prev;
        addr_t prev;
        hit   = -1;
        empty = -1;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_addr[i] == a)
                hit = i;
            if (!slot_used[i])
                empty = i;
        end
        case (f)
            FN_START:
            begin
                tracking_on = 1'b1;
                expected_q.push_back('{ST_OK, ADDR_ZERO, 1'b1});
            end
            FN_STOP:
            begin
                tracking_on = 1'b0;
                expected_q.push_back('{ST_OK, ADDR_ZERO, 1'b1});
            end
            FN_ALLOC:
            begin
                if (!tracking_on)
                    expected_q.push_back('{ST_NOT_REC, a, 1'b1});
                else if (a == ADDR_ZERO)
                    expected_q.push_back('{ST_HEAP_FULL, ADDR_ZERO, 1'b1});
                else if (hit >= 0 && slot_freed[hit])
                begin
                    slot_freed[hit] = 1'b0;
                    expected_q.push_back('{ST_OK, a, 1'b1});
                end
                else if (hit >= 0)
                    expected_q.push_back('{ST_LIVE_REALLOC, a, 1'b1});
                else if (empty < 0)
                    expected_q.push_back('{ST_TABLE_FULL, a, 1'b1});
                else
                begin
                    slot_used[empty]  = 1'b1;
                    slot_addr[empty]  = a;
                    slot_freed[empty] = 1'b0;
                    expected_q.push_back('{ST_OK, a, 1'b1});
                end
            end
            FN_FREE:
            begin
                if (!tracking_on)
                    expected_q.push_back('{ST_NOT_REC, a, 1'b1});
                else if (hit < 0)
                    expected_q.push_back('{ST_UNALLOC_FREE, a, 1'b1});
                else if (slot_freed[hit])
                    expected_q.push_back('{ST_DOUBLE_FREE, a, 1'b1});
                else
                begin
                    slot_freed[hit] = 1'b1;
                    expected_q.push_back('{ST_OK, a, 1'b1});
                end
            end
            FN_FINISH:
            begin
                // live entries in ascending address order, then done
                have_prev = 1'b0;
                prev      = '0;
                do
                begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (slot_used[i] && !slot_freed[i]
                            && (!have_prev || slot_addr[i] > prev)
                            && (best < 0 || slot_addr[i] < slot_addr[best]))
                            best = i;
                    end
                    if (best >= 0)
                    begin
                        expected_q.push_back('{ST_LEAK, slot_addr[best], 1'b0});
                        prev      = slot_addr[best];
                        have_prev = 1'b1;
                    end
                end
                while (best >= 0);
                expected_q.push_back('{ST_DONE, ADDR_ZERO, 1'b1});
            end
            default:
                expected_q.push_back('{ST_OK, ADDR_ZERO, 1'b1});
        endcase
    endfunction

    function automatic void report_failure(input string what, input report_t want,
                                           input report_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch (%s) at cycle %0d: expected status %0d addr %h last %b,"
                     , what, cycle_count, want.status, want.addr, want.last,
                     " got status %0d addr %h last %b", got.status, got.addr, got.last);
    endfunction

    // Request driver; the request is handed to the shadow table once accepted
    task automatic send_request(input step_row_t row);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            event_ch.valid <= 1'b0;
            @(posedge clk);
        end
        event_ch.valid <= 1'b1;
        event_ch.func  <= row.func;
        event_ch.addr  <= row.addr;
        @(posedge clk);
        while (!event_ch.ready)
            @(posedge clk);
        track_request(row.func, row.addr);
        if (row.typed)
        begin
            void'(expected_q.pop_back());
            expected_q.push_back('{row.status, row.rep_addr, 1'b1});
        end
    endtask

    // Result receiver with random stalls
    initial
    begin
        report_t got;
        report_t want;
        int      stall;
        result_ch.ready <= 1'b0;
        forever
        begin
            stall = draw_wait();
            repeat (stall)
            begin
                result_ch.ready <= 1'b0;
                @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            got = '{result_ch.status, result_ch.report_addr, result_ch.last};
            if (expected_q.size() == 0)
                report_failure("unexpected result", '0, got);
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                    report_failure("field", want, got);
            end
        end
    end

    // Reset, directed table, random requests, drain
    initial
    begin
        step_row_t row;
        int        pick;
        int        idx;
        int        window;
        rst_n          <= 1'b0;
        event_ch.valid <= 1'b0;
        event_ch.func  <= FN_START;
        event_ch.addr  <= '0;
        clear_table();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIRECTED_ROWS; k++)
            send_request(DIRECTED[k]);

        // Address pool; odd entries differ from their neighbor in one bit
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            if (k % 2 == 1)
                addr_pool[k] = addr_pool[k-1] ^ (addr_t'(1) << $urandom_range(0, 63));
            else
                addr_pool[k] = rand_addr();
        end

        // Pool window grows so the table fills gradually and then overflows
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            quiet_phase = ((n / 40) % 3 == 2);
            pick   = $urandom_range(0, 99);
            window = (4 + n / 8 < POOL_SIZE - 1) ? 4 + n / 8 : POOL_SIZE - 1;
            idx    = $urandom_range(0, window);
            row    = '{FN_START, ADDR_ZERO, 1'b0, ST_OK, ADDR_ZERO};
            if (!tracking_on && pick < 60)
                row.addr = rand_addr();
            else if (pick < 40)
                row = '{FN_ALLOC, addr_pool[idx], 1'b0, ST_OK, ADDR_ZERO};
            else if (pick < 70)
                row = '{FN_FREE, addr_pool[idx], 1'b0, ST_OK, ADDR_ZERO};
            else if (pick < 75)
                row = '{FN_FINISH, rand_addr(), 1'b0, ST_OK, ADDR_ZERO};
            else if (pick < 80)
                row.addr = rand_addr();
            else if (pick < 84)
                row = '{FN_STOP, rand_addr(), 1'b0, ST_OK, ADDR_ZERO};
            else if (pick < 90)
                row = '{FN_FREE, rand_addr(), 1'b0, ST_OK, ADDR_ZERO};
            else if (pick < 94)
                row = '{FN_ALLOC, rand_addr(), 1'b0, ST_OK, ADDR_ZERO};
            else if (pick < 96)
                row = '{FN_ALLOC, ADDR_ZERO, 1'b0, ST_OK, ADDR_ZERO};
            else if (pick < 97)
                row = '{FN_FREE, ADDR_ZERO, 1'b0, ST_OK, ADDR_ZERO};
            else
                row = '{func_t'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), rand_addr(),
                        1'b0, ST_OK, ADDR_ZERO};
            send_request(row);
        end
        event_ch.valid <= 1'b0;
        quiet_phase = 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("PASS allocation_tracker_table");
        else
            $display("FAIL allocation_tracker_table");
        $finish;
    end

endmodule
